// ----- rtl/lfw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lfw_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FADE_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRIGHTNESS = 2'd2;

    localparam int unsigned MODE_W   = 3;
    localparam int unsigned PERIOD_W = 24;
    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned PHASE_W  = 25;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned COLOUR_W = 3;

    localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SINE     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SQUARE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRIANGLE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SAWTOOTH = 3'd4;
    localparam logic [MODE_W-1:0] MODE_COLOUR   = 3'd5;

    // serial multiplier: 25 x 8 bits, one multiplier bit per cycle
    localparam int unsigned MUL_A_W   = 25;
    localparam int unsigned MUL_B_W   = 8;
    localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_B_W + 1);

    // serial divider: 34 bit dividend, 24 bit divisor, one quotient bit per cycle
    localparam int unsigned DIV_N_W   = 34;
    localparam int unsigned DIV_D_W   = 24;
    localparam int unsigned DIV_Q_W   = 10;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam int unsigned SINE_IDX_W = 9;
    localparam int unsigned SINE_W     = 15;
    localparam int unsigned SINE_DEPTH = 257;

    typedef logic [SINE_W-1:0] t_sine_table [SINE_DEPTH];

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } t_mul_sts;

    typedef struct packed {
        logic               done;
        logic               zero;
        logic               over;
        logic [DIV_Q_W-1:0] quot;
    } t_div_sts;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    // sin(q*pi/512) in Q15 from a Q30 Taylor polynomial
    function automatic logic [SINE_W-1:0] sine_quarter(input int unsigned q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (64'(q) * PI_Q30) >> 9;
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (((x * t) >> 30) + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[SINE_W-1:0];
    endfunction

    function automatic t_sine_table build_sine_table();
        t_sine_table tab;
        for (int unsigned i = 0; i < SINE_DEPTH; i++) begin
            tab[i] = sine_quarter(i);
        end
        return tab;
    endfunction

    localparam t_sine_table SINE_QUARTER = build_sine_table();

endpackage

`default_nettype wire

// ----- rtl/lfw_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lfw_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

`default_nettype wire

// ----- rtl/lfw_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface lfw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] brightness;
    logic [2:0] colour_index;
    logic       colour_changed;

    modport source (output valid, output brightness, output colour_index,
                    output colour_changed, input ready);
    modport sink   (input valid, input brightness, input colour_index,
                    input colour_changed, output ready);
endinterface

`default_nettype wire

// ----- rtl/lfw_serial_mult.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lfw_serial_mult
    import lfw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [MUL_A_W-1:0] i_a,
    input  wire logic [MUL_B_W-1:0] i_b,
    output t_mul_sts                o_sts
);

    logic [MUL_A_W-1:0]   r_a;
    logic [MUL_B_W-1:0]   r_b;
    logic [MUL_P_W-1:0]   r_acc;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [MUL_P_W-1:0]   n_acc;

    // msb first shift and add
    always_comb begin
        n_acc = {r_acc[MUL_P_W-2:0], 1'b0}
              + (r_b[MUL_B_W-1] ? MUL_P_W'(r_a) : MUL_P_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= MUL_CNT_W'(MUL_B_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == MUL_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            r_b   <= {r_b[MUL_B_W-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.prod = r_acc;

endmodule

`default_nettype wire

// ----- rtl/lfw_serial_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lfw_serial_div
    import lfw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DIV_N_W-1:0] i_num,
    input  wire logic [DIV_D_W-1:0] i_den,
    output t_div_sts                o_sts
);

    logic [DIV_N_W-1:0]   r_num;
    logic [DIV_D_W-1:0]   r_den;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_Q_W-1:0]   r_quot;
    logic                 r_sticky;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [DIV_D_W:0]     n_shift;
    logic [DIV_D_W:0]     n_trial;
    logic                 n_qbit;
    logic [DIV_D_W-1:0]   n_rem;

    // restoring division, one quotient bit a cycle
    always_comb begin
        n_shift = {r_rem, r_num[DIV_N_W-1]};
        n_trial = n_shift - {1'b0, r_den};
        n_qbit  = !n_trial[DIV_D_W];
        n_rem   = n_qbit ? n_trial[DIV_D_W-1:0] : n_shift[DIV_D_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= DIV_CNT_W'(DIV_N_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == DIV_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // only the low quotient bits are kept; anything above bit 7 sets the sticky flag
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num    <= i_num;
            r_den    <= i_den;
            r_rem    <= '0;
            r_quot   <= '0;
            r_sticky <= 1'b0;
        end else if (r_cnt != '0) begin
            r_num    <= {r_num[DIV_N_W-2:0], 1'b0};
            r_rem    <= n_rem;
            r_quot   <= {r_quot[DIV_Q_W-2:0], n_qbit};
            r_sticky <= r_sticky | r_quot[LEVEL_W-1];
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.zero = (r_den == '0);
    assign o_sts.over = r_sticky | (|r_quot[DIV_Q_W-1:LEVEL_W]);
    assign o_sts.quot = r_quot;

endmodule

`default_nettype wire

// ----- rtl/led_fade_waveform_generator_core.sv -----
// LED fade waveform generator.
// i_in carries one word per millisecond tick: the free-running time now_ms.
// When the mode is active and more than STEP ms have gone by since the last
// update, the block puts one word on o_out: brightness for the current phase,
// colour index and a colour-changed flag; the phase then advances by STEP,
// or wraps to 0 once past the period. Otherwise the input word is consumed
// and nothing is produced. Registers are written on i_cfg_we: index 0 fade
// mode, 1 period, 2 peak. One word is processed at a time; i_in.ready is
// high while idle. Square takes its level straight from the phase; sine
// runs the bit-serial divider and then the bit-serial multiplier; triangle
// and sawtooth run the multiplier and then the divider. An inactive or early
// word frees the input again once the check state is left.
// The result sits in an output register; a new word may be accepted while it
// waits. If the receiver stalls, a finished result holds in the sequencer
// until the output register is free, and the input stays not ready.
// Synchronous reset clears registers, phase, last update time and colour.
`timescale 1ns / 1ps
`default_nettype none

module led_fade_waveform_generator_core
    import lfw_pkg::*;
#(
    parameter int unsigned STEP         = 10,
    parameter int unsigned COLOUR_COUNT = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lfw_in_if.sink                     i_in,
    lfw_out_if.source                  o_out
);

    localparam logic [TIME_W-1:0]  STEP_T  = TIME_W'(STEP);
    localparam logic [PHASE_W-1:0] STEP_P  = PHASE_W'(STEP);
    localparam logic [COLOUR_W:0]  COLOURS = (COLOUR_W + 1)'(COLOUR_COUNT);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SMUL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]            r_state;
    logic [MODE_W-1:0]     r_mode;
    logic [PERIOD_W-1:0]   r_period;
    logic [LEVEL_W-1:0]    r_max;
    logic [PHASE_W-1:0]    r_phase;
    logic [TIME_W-1:0]     r_last;
    logic [COLOUR_W-1:0]   r_colour;
    logic [TIME_W-1:0]     r_now;
    logic [DIV_D_W-1:0]    r_den;
    logic                  r_neg;
    logic [LEVEL_W-1:0]    r_level;

    logic                  r_out_valid;
    logic [LEVEL_W-1:0]    r_out_level;
    logic [COLOUR_W-1:0]   r_out_colour;
    logic                  r_out_changed;

    logic [PERIOD_W-2:0]   half;
    logic                  below_half;
    logic                  is_sine;
    logic                  active;
    logic                  due;
    logic [MUL_A_W-1:0]    tri_op;

    logic                  mul_start;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    t_mul_sts              mul_sts;
    logic                  div_start;
    logic [DIV_N_W-1:0]    div_num;
    logic [DIV_D_W-1:0]    div_den;
    t_div_sts              div_sts;

    logic [DIV_Q_W-1:0]    sine_idx;
    logic [SINE_IDX_W-1:0] sine_q;
    logic [SINE_W-1:0]     sine_mag;
    logic [22:0]           sine_base;
    logic [22:0]           sine_part;
    logic [22:0]           sine_total;
    logic [LEVEL_W-1:0]    div_level;

    logic                  out_free;
    logic [PHASE_W-1:0]    n_phase;
    logic                  wrap;
    logic [COLOUR_W:0]     n_colour_inc;
    logic [COLOUR_W-1:0]   n_colour;
    logic                  n_changed;

    lfw_serial_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_sts   (mul_sts)
    );

    lfw_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_sts   (div_sts)
    );

    always_comb begin
        half       = r_period[PERIOD_W-1:1];
        below_half = (r_phase < PHASE_W'(half));
        is_sine    = (r_mode == MODE_SINE) || (r_mode == MODE_COLOUR);
        active     = (r_mode != MODE_NONE) && (r_mode <= MODE_COLOUR);
        due        = ((r_now - r_last) > STEP_T);

        if (below_half) begin
            tri_op = r_phase;
        end else if (r_phase >= PHASE_W'(r_period)) begin
            tri_op = '0;
        end else begin
            tri_op = PHASE_W'(r_period) - r_phase;
        end

        sine_idx = div_sts.zero ? DIV_Q_W'(0) : div_sts.quot;
        if (sine_idx[8]) begin
            sine_q = SINE_IDX_W'(256) - {1'b0, sine_idx[7:0]};
        end else begin
            sine_q = {1'b0, sine_idx[7:0]};
        end
        sine_mag = SINE_QUARTER[sine_q];

        sine_base  = {1'b0, r_max, 14'd0};
        sine_part  = mul_sts.prod[22:0];
        sine_total = r_neg ? sine_base - sine_part : sine_base + sine_part;

        if (div_sts.zero) begin
            div_level = '0;
        end else if (div_sts.over) begin
            div_level = '1;
        end else begin
            div_level = div_sts.quot[LEVEL_W-1:0];
        end

        mul_start = 1'b0;
        mul_a     = tri_op;
        mul_b     = r_max;
        div_start = 1'b0;
        div_num   = {r_phase, 9'd0};
        div_den   = r_den;
        unique case (r_state)
            S_CHECK: begin
                if (active && due && !is_sine && (r_mode != MODE_SQUARE)) begin
                    mul_start = 1'b1;
                    mul_a     = (r_mode == MODE_SAWTOOTH) ? r_phase : tri_op;
                end
                if (active && due && is_sine) begin
                    div_start = 1'b1;
                    div_den   = {1'b0, half};
                end
            end
            S_MUL: begin
                div_start = mul_sts.done;
                div_num   = {1'b0, mul_sts.prod};
            end
            S_DIV: begin
                mul_start = div_sts.done && is_sine;
                mul_a     = MUL_A_W'(sine_mag);
                mul_b     = {1'b0, r_max[LEVEL_W-1:1]};
            end
            S_IDLE, S_SMUL, S_DONE: begin
            end
            default: begin
            end
        endcase

        out_free     = !r_out_valid || o_out.ready;
        n_phase      = r_phase + STEP_P;
        wrap         = (n_phase > PHASE_W'(r_period));
        n_colour_inc = {1'b0, r_colour} + 1'b1;
        n_changed    = wrap && (r_mode == MODE_COLOUR);
        if (!n_changed) begin
            n_colour = r_colour;
        end else if (n_colour_inc >= COLOURS) begin
            n_colour = '0;
        end else begin
            n_colour = n_colour_inc[COLOUR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NONE;
            r_period <= '0;
            r_max    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FADE_MODE:      r_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_PERIOD_MS:      r_period <= i_cfg_data[PERIOD_W-1:0];
                CFG_MAX_BRIGHTNESS: r_max    <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= '0;
            r_last   <= '0;
            r_colour <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!active || !due) begin
                        r_state <= S_IDLE;
                    end else if (is_sine) begin
                        r_state <= S_DIV;
                    end else if (r_mode == MODE_SQUARE) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mul_sts.done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_sts.done) begin
                        r_state <= is_sine ? S_SMUL : S_DONE;
                    end
                end
                S_SMUL: begin
                    if (mul_sts.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state  <= S_IDLE;
                        r_phase  <= wrap ? PHASE_W'(0) : n_phase;
                        r_last   <= r_now;
                        r_colour <= n_colour;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_now <= i_in.now_ms;
        end
        if (r_state == S_CHECK) begin
            r_den   <= (r_mode == MODE_SAWTOOTH) ? r_period : {1'b0, half};
            r_level <= below_half ? r_max : LEVEL_W'(0);
        end
        if (r_state == S_DIV && div_sts.done) begin
            r_neg <= sine_idx[9];
            if (!is_sine) begin
                r_level <= div_level;
            end
        end
        if (r_state == S_SMUL && mul_sts.done) begin
            r_level <= sine_total[22:15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_level   <= r_level;
            r_out_colour  <= n_colour;
            r_out_changed <= n_changed;
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.brightness     = r_out_level;
    assign o_out.colour_index   = r_out_colour;
    assign o_out.colour_changed = r_out_changed;

endmodule

`default_nettype wire
